### hdl/tscc_pkg.sv
// ---------------------------------------------------------------------------
// tscc_pkg
// shared types and constants of the slope cone compressor
// ---------------------------------------------------------------------------
package tscc_pkg;

   localparam int POINT_WIDTH   = 31;
   localparam int TOL_WIDTH     = 20;
   localparam int SLOPE_WIDTH   = 48;
   localparam int OPERAND_WIDTH = 34;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic signed [SLOPE_WIDTH-1:0] SLOPE_MAX = {1'b0, {(SLOPE_WIDTH-1){1'b1}}};
   localparam logic signed [SLOPE_WIDTH-1:0] SLOPE_MIN = {1'b1, {(SLOPE_WIDTH-1){1'b0}}};

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DISTANCE_TOLERANCE = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TIME_TOLERANCE     = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EMIT_FIRST,
      ST_START,
      ST_WAIT,
      ST_EMIT_BREAK,
      ST_FINISH,
      ST_EMIT_FINAL
   } state_type;

   typedef enum logic [2:0] {
      OP_TEST,
      OP_LOW_DIST,
      OP_HIGH_DIST,
      OP_LOW_TIME,
      OP_HIGH_TIME
   } op_type;

   typedef struct packed {
      logic                            start;
      logic signed [OPERAND_WIDTH-1:0] num;
      logic signed [OPERAND_WIDTH-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                          busy;
      logic                          done;
      logic signed [SLOPE_WIDTH-1:0] slope;
   } div_rsp_type;

endpackage

### hdl/tscc_req_if.sv
// ---------------------------------------------------------------------------
// tscc_req_if
// input item channel: one trajectory point
// ---------------------------------------------------------------------------
interface tscc_req_if;
   logic        valid;
   logic        ready;
   logic [30:0] point_distance;
   logic [30:0] point_time;
   logic        first_point;
   logic        final_point;

   modport source (output valid, point_distance, point_time, first_point, final_point,
                   input ready);
   modport sink (input valid, point_distance, point_time, first_point, final_point,
                 output ready);
endinterface

### hdl/tscc_rsp_if.sv
// ---------------------------------------------------------------------------
// tscc_rsp_if
// result item channel: one retained point
// ---------------------------------------------------------------------------
interface tscc_rsp_if;
   logic        valid;
   logic        ready;
   logic [30:0] kept_distance;
   logic [30:0] kept_time;
   logic        trajectory_end;
   logic        run_last;

   modport source (output valid, kept_distance, kept_time, trajectory_end, run_last,
                   input ready);
   modport sink (input valid, kept_distance, kept_time, trajectory_end, run_last,
                 output ready);
endinterface

### hdl/tscc_div.sv
// ---------------------------------------------------------------------------
// tscc_div
// iterative signed slope divider, one quotient bit per cycle, saturating
// ---------------------------------------------------------------------------
module tscc_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tscc_pkg::div_req_type div_req,
   output tscc_pkg::div_rsp_type div_rsp
);
   import tscc_pkg::*;

   localparam int MW = OPERAND_WIDTH - 1;
   localparam int DW = MW + FRAC_BITS;
   localparam int RW = MW + 1;
   localparam int CW = $clog2(DW + 1);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [DW-1:0]          dvd_ff, dvd_in;
   logic [RW-1:0]          rem_ff, rem_in;
   logic [MW-1:0]          den_ff, den_in;
   logic                   neg_ff, neg_in;
   logic signed [SLOPE_WIDTH-1:0] slope_ff, slope_in;

   logic [MW-1:0]          num_mag, den_mag;
   logic [RW-1:0]          rem_shift;
   logic                   fits;
   logic [DW-1:0]          q_next;
   logic [63:0]            q_wide;

   always_comb begin
      num_mag   = div_req.num[OPERAND_WIDTH-1] ? MW'(-div_req.num) : div_req.num[MW-1:0];
      den_mag   = div_req.den[OPERAND_WIDTH-1] ? MW'(-div_req.den) : div_req.den[MW-1:0];
      rem_shift = {rem_ff[RW-2:0], dvd_ff[DW-1]};
      fits      = rem_shift >= {1'b0, den_ff};
      q_next    = {dvd_ff[DW-2:0], fits};
      q_wide    = 64'(q_next);
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      slope_in = slope_ff;
      if (div_req.start) begin
         if (div_req.den == '0) begin
            done_in = 1'b1;
            if (div_req.num == '0) begin
               slope_in = '0;
            end else if (div_req.num[OPERAND_WIDTH-1]) begin
               slope_in = SLOPE_MIN;
            end else begin
               slope_in = SLOPE_MAX;
            end
         end else begin
            busy_in  = 1'b1;
            count_in = CW'(DW);
            dvd_in   = {num_mag, {FRAC_BITS{1'b0}}};
            rem_in   = '0;
            den_in   = den_mag;
            neg_in   = div_req.num[OPERAND_WIDTH-1] ^ div_req.den[OPERAND_WIDTH-1];
         end
      end else if (busy_ff) begin
         rem_in   = fits ? rem_shift - {1'b0, den_ff} : rem_shift;
         dvd_in   = q_next;
         count_in = count_ff - 1'b1;
         if (count_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (neg_ff) begin
               slope_in = (q_wide > 64'(SLOPE_MAX) + 64'd1) ? SLOPE_MIN
                                                           : SLOPE_WIDTH'(-q_wide);
            end else begin
               slope_in = (q_wide > 64'(SLOPE_MAX)) ? SLOPE_MAX : SLOPE_WIDTH'(q_wide);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      neg_ff   <= neg_in;
      slope_ff <= slope_in;
   end

   assign div_rsp.busy  = busy_ff;
   assign div_rsp.done  = done_ff;
   assign div_rsp.slope = slope_ff;

endmodule

### hdl/trajectory_slope_cone_compressor.sv
// ---------------------------------------------------------------------------
// trajectory_slope_cone_compressor
// swinging door compression of (distance, time) trajectory points
// ---------------------------------------------------------------------------
// One point is taken at a time. A first point (or one arriving with no open
// trajectory) waits only for the result register. Any other point runs four
// to six slope divisions in sequence through a single bit-serial divider, plus
// a result item on a break or a final point and any stall on the result side.
// Tolerances are to be written only while the block is idle; the block itself
// does not enforce this.
module trajectory_slope_cone_compressor #(
   parameter int SLOPE_FRACTION_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   tscc_req_if.sink                            req_chan,
   tscc_rsp_if.source                          rsp_chan,
   input  logic                                csr_write_enable,
   input  logic [tscc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [tscc_pkg::TOL_WIDTH-1:0]       csr_write_data
);
   import tscc_pkg::*;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   logic [TOL_WIDTH-1:0]   tol_d_ff, tol_t_ff;
   logic [POINT_WIDTH-1:0] pd_ff, pt_ff, anchor_d_ff, anchor_t_ff, prev_d_ff, prev_t_ff;
   logic                   first_ff, final_ff, inside_ff;
   logic signed [SLOPE_WIDTH-1:0] lower_ff, upper_ff;
   logic                   rsp_valid_ff;
   logic [POINT_WIDTH-1:0] rsp_d_ff, rsp_t_ff;
   logic                   rsp_end_ff, rsp_last_ff;

   logic signed [OPERAND_WIDTH-1:0] dd, dt, tol_d_ext, tol_t_ext;
   logic                            out_free, accept, outside, emit;
   div_req_type div_req;
   div_rsp_type div_rsp;

   tscc_div #(.FRAC_BITS(SLOPE_FRACTION_BITS)) u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      dd        = $signed({3'b0, pd_ff}) - $signed({3'b0, anchor_d_ff});
      dt        = $signed({3'b0, pt_ff}) - $signed({3'b0, anchor_t_ff});
      tol_d_ext = $signed({14'b0, tol_d_ff});
      tol_t_ext = $signed({14'b0, tol_t_ff});
      out_free  = !rsp_valid_ff || rsp_chan.ready;
      accept    = req_chan.valid && req_chan.ready;
      outside   = (div_rsp.slope < lower_ff) || (div_rsp.slope > upper_ff);
      emit      = out_free && (state_ff inside {ST_EMIT_FIRST, ST_EMIT_BREAK, ST_EMIT_FINAL});
   end

   // divider operands
   always_comb begin
      div_req.start = (state_ff == ST_START);
      div_req.num   = dd;
      div_req.den   = dt;
      case (op_ff)
         OP_TEST:      begin div_req.num = dd; div_req.den = dt; end
         OP_LOW_DIST:  begin div_req.num = dd - tol_d_ext; end
         OP_HIGH_DIST: begin div_req.num = dd + tol_d_ext; end
         OP_LOW_TIME:  begin div_req.den = dt + tol_t_ext; end
         OP_HIGH_TIME: begin div_req.den = dt - tol_t_ext; end
         default:      begin div_req.num = dd; end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in = OP_TEST;
               if (req_chan.first_point || !inside_ff) begin
                  state_in = ST_EMIT_FIRST;
               end else begin
                  state_in = ST_START;
               end
            end
         end
         ST_EMIT_FIRST: if (out_free) state_in = ST_IDLE;
         ST_START:      state_in = ST_WAIT;
         ST_WAIT: begin
            if (div_rsp.done) begin
               case (op_ff)
                  OP_TEST: begin
                     if (outside) begin
                        state_in = ST_EMIT_BREAK;
                     end else begin
                        op_in    = OP_LOW_DIST;
                        state_in = ST_START;
                     end
                  end
                  OP_LOW_DIST: begin op_in = OP_HIGH_DIST; state_in = ST_START; end
                  OP_HIGH_DIST: begin op_in = OP_LOW_TIME; state_in = ST_START; end
                  OP_LOW_TIME: begin
                     if (dt > tol_t_ext) begin
                        op_in    = OP_HIGH_TIME;
                        state_in = ST_START;
                     end else begin
                        state_in = ST_FINISH;
                     end
                  end
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_EMIT_BREAK: begin
            if (out_free) begin
               op_in    = OP_LOW_DIST;
               state_in = ST_START;
            end
         end
         ST_FINISH:     state_in = final_ff ? ST_EMIT_FINAL : ST_IDLE;
         ST_EMIT_FINAL: if (out_free) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_chan.ready          = (state_ff == ST_IDLE);
      rsp_chan.valid          = rsp_valid_ff;
      rsp_chan.kept_distance  = rsp_d_ff;
      rsp_chan.kept_time      = rsp_t_ff;
      rsp_chan.trajectory_end = rsp_end_ff;
      rsp_chan.run_last       = rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_TEST;
         tol_d_ff     <= '0;
         tol_t_ff     <= '0;
         anchor_d_ff  <= '0;
         anchor_t_ff  <= '0;
         prev_d_ff    <= '0;
         prev_t_ff    <= '0;
         lower_ff     <= SLOPE_MIN;
         upper_ff     <= SLOPE_MAX;
         inside_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_DISTANCE_TOLERANCE: tol_d_ff <= csr_write_data;
               CSR_TIME_TOLERANCE:     tol_t_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (emit) rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_EMIT_FIRST: begin
               if (out_free) begin
                  rsp_d_ff     <= pd_ff;
                  rsp_t_ff     <= pt_ff;
                  rsp_end_ff   <= final_ff;
                  rsp_last_ff  <= 1'b1;
                  anchor_d_ff  <= pd_ff;
                  anchor_t_ff  <= pt_ff;
                  prev_d_ff    <= pd_ff;
                  prev_t_ff    <= pt_ff;
                  lower_ff     <= SLOPE_MIN;
                  upper_ff     <= SLOPE_MAX;
                  inside_ff    <= !final_ff;
               end
            end
            ST_WAIT: begin
               if (div_rsp.done) begin
                  case (op_ff)
                     OP_LOW_DIST, OP_LOW_TIME: begin
                        if (div_rsp.slope > lower_ff) lower_ff <= div_rsp.slope;
                     end
                     OP_HIGH_DIST, OP_HIGH_TIME: begin
                        if (div_rsp.slope < upper_ff) upper_ff <= div_rsp.slope;
                     end
                     default: ;
                  endcase
               end
            end
            ST_EMIT_BREAK: begin
               if (out_free) begin
                  rsp_d_ff     <= prev_d_ff;
                  rsp_t_ff     <= prev_t_ff;
                  rsp_end_ff   <= 1'b0;
                  rsp_last_ff  <= !final_ff;
                  anchor_d_ff  <= prev_d_ff;
                  anchor_t_ff  <= prev_t_ff;
                  lower_ff     <= SLOPE_MIN;
                  upper_ff     <= SLOPE_MAX;
               end
            end
            ST_FINISH: begin
               prev_d_ff <= pd_ff;
               prev_t_ff <= pt_ff;
            end
            ST_EMIT_FINAL: begin
               if (out_free) begin
                  rsp_d_ff     <= pd_ff;
                  rsp_t_ff     <= pt_ff;
                  rsp_end_ff   <= 1'b1;
                  rsp_last_ff  <= 1'b1;
                  inside_ff    <= 1'b0;
               end
            end
            default: ;
         endcase
      end
      if (accept) begin
         pd_ff    <= req_chan.point_distance;
         pt_ff    <= req_chan.point_time;
         first_ff <= req_chan.first_point;
         final_ff <= req_chan.final_point;
      end
   end

   // a first point never enters the divider path
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_START) |-> !first_ff)
      else $error("first point sent to divider");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !div_rsp.busy)
      else $error("divider busy while idle");

   assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> $past(state_ff) == ST_WAIT || $past(state_ff) == ST_START)
      else $error("divider result outside of wait");

   assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.first_point) |=> (state_ff == ST_EMIT_FIRST))
      else $error("first point not emitted directly");

endmodule
